// ===== rtl/twscr_pkg.sv =====
// Shared types and constants for the two-wire signal command receiver.
// No dependencies; every other file in rtl/ imports this package.
package twscr_pkg;

    // Frame length and bit counter width
    localparam int FRAME_BITS = 16;
    localparam int COUNT_W    = $clog2(FRAME_BITS);

    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [FRAME_BITS-1:0] word_t;

    // Station address after reset
    localparam logic [7:0] BOOT_ADDR_RESET = 8'h04;

    // Address that reprograms the station address
    localparam logic [7:0] PROG_CHANNEL = 8'hff;

    // Lamp commands
    localparam logic [7:0] CMD_RED   = 8'h00;
    localparam logic [7:0] CMD_GREEN = 8'h01;
    localparam logic [7:0] CMD_DARK  = 8'h0d;

    // One sample of the bus lines
    typedef struct packed {
        logic scl_level;
        logic sda_level;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic       red_lamp;
        logic       green_lamp;
        logic       relay_on;
        logic       frame_done;
        logic [7:0] frame_addr;
        logic [7:0] frame_data;
        logic [7:0] station_id;
    } out_item_t;

    // Lamp and relay drive state
    typedef struct packed {
        logic relay;
        logic green;
        logic red;
    } lamp_t;

    // Input register contents handed to the decoder
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

// ===== rtl/two_wire_signal_command_receiver_unit.sv =====
// Top level of the two-wire signal command receiver: input register, decoder, result register.
// Depends on twscr_pkg, twscr_in_stage and twscr_frame_decoder.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------
//  input     | in_valid / in_ready   | in_data  (scl_level, sda_level)
//  result    | out_valid / out_ready | out_data (lamps, relay, frame, id)
//  register  | cfg_we                | cfg_wdata (boot_address)
//
// One sample per cycle unless stalled; each gives one result via input, then result register.
// The rate is set by the single decoder pass between the input and result registers.
// A stalled result register holds the input register, which then holds in_ready low.
// Reset clears the frame state, lights the red lamp and loads station address 4.
module two_wire_signal_command_receiver_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  twscr_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output twscr_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata
);
    import twscr_pkg::*;

    stage_t    stage;
    out_item_t result;
    logic      advance;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Move the held sample on when the result register is free or drains
    assign advance = stage.valid && (!out_valid_reg || out_ready);

    twscr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .stage    (stage)
    );

    twscr_frame_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // A sample that moves on shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced sample produced no result");

    // An input transfer leaves a sample in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stage.valid)
        else $error("accepted sample lost from input register");

endmodule

// ===== rtl/twscr_in_stage.sv =====
// Input register of the receiver: holds one accepted bus sample.
// Depends on twscr_pkg.
module twscr_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  twscr_pkg::in_item_t in_data,
    input  logic                advance,
    output twscr_pkg::stage_t   stage
);
    import twscr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Take a new sample whenever the register is empty or drains this cycle
    assign in_ready = !valid_reg || advance;

    // Hold the sample until the decoder consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== rtl/twscr_frame_decoder.sv =====
// Frame decoder: start detection, bit capture, slot pairing, lamp and address update.
// Depends on twscr_pkg.
module twscr_frame_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  twscr_pkg::stage_t    stage,
    input  logic                 advance,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    output twscr_pkg::out_item_t result
);
    import twscr_pkg::*;

    logic       receiving_reg,   receiving_next;
    count_t     bit_count_reg,   bit_count_next;
    word_t      shift_word_reg,  shift_word_next;
    logic       prev_scl_reg;
    logic       prev_sda_reg;
    logic       pair_slot_reg,   pair_slot_next;
    logic [7:0] first_data_reg,  first_data_next;
    logic [7:0] second_data_reg, second_data_next;
    logic [7:0] last_addr_reg,   last_addr_next;
    logic [7:0] station_reg,     station_next;
    lamp_t      lamp_reg,        lamp_next;
    logic       done;
    logic       scl;
    logic       sda;
    logic       scl_rise;
    word_t      word_upd;

    assign scl      = stage.item.scl_level;
    assign sda      = stage.item.sda_level;
    assign scl_rise = scl && !prev_scl_reg;

    // Clear the addressed bit when the data line is low
    always_comb
    begin
        word_upd = shift_word_reg;
        if (!sda)
        begin
            word_upd[bit_count_reg] = 1'b0;
        end
    end

    // Work out the next state for the sample in the input register
    always_comb
    begin
        receiving_next   = receiving_reg;
        bit_count_next   = bit_count_reg;
        shift_word_next  = shift_word_reg;
        pair_slot_next   = pair_slot_reg;
        first_data_next  = first_data_reg;
        second_data_next = second_data_reg;
        last_addr_next   = last_addr_reg;
        station_next     = station_reg;
        lamp_next        = lamp_reg;
        done             = 1'b0;

        if (!receiving_reg)
        begin
            // Start condition: data falls while the clock is high
            if (scl && prev_sda_reg && !sda)
            begin
                receiving_next  = 1'b1;
                bit_count_next  = '0;
                shift_word_next = '1;
            end
        end
        else if (scl_rise)
        begin
            if (bit_count_reg == count_t'(FRAME_BITS - 1))
            begin
                // Last bit in: close the frame and file the command
                done           = 1'b1;
                receiving_next = 1'b0;
                bit_count_next = '0;
                shift_word_next = '1;
                last_addr_next = word_upd[7:0];
                if (!pair_slot_reg)
                begin
                    first_data_next = word_upd[15:8];
                end
                else
                begin
                    second_data_next = word_upd[15:8];
                end
                pair_slot_next = !pair_slot_reg;

                // Act only when both slots agree
                if (first_data_next == second_data_next)
                begin
                    if (last_addr_next == station_reg)
                    begin
                        case (first_data_next)
                            CMD_RED:   lamp_next = '{relay: 1'b0, green: 1'b0, red: 1'b1};
                            CMD_GREEN: lamp_next = '{relay: 1'b1, green: 1'b1, red: 1'b0};
                            CMD_DARK:  lamp_next = '{relay: 1'b0, green: 1'b0, red: 1'b0};
                            default:   lamp_next = lamp_reg;
                        endcase
                    end
                    if (last_addr_next == PROG_CHANNEL && first_data_next != 8'h00)
                    begin
                        station_next = first_data_next;
                    end
                end
            end
            else
            begin
                shift_word_next = word_upd;
                bit_count_next  = bit_count_reg + count_t'(1);
            end
        end
    end

    // Advance the state when the sample moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            bit_count_reg   <= '0;
            shift_word_reg  <= '1;
            prev_scl_reg    <= 1'b1;
            prev_sda_reg    <= 1'b1;
            pair_slot_reg   <= 1'b0;
            first_data_reg  <= '0;
            second_data_reg <= '0;
            last_addr_reg   <= '0;
            station_reg     <= BOOT_ADDR_RESET;
            lamp_reg        <= '{relay: 1'b0, green: 1'b0, red: 1'b1};
        end
        else
        begin
            if (advance)
            begin
                receiving_reg   <= receiving_next;
                bit_count_reg   <= bit_count_next;
                shift_word_reg  <= shift_word_next;
                prev_scl_reg    <= scl;
                prev_sda_reg    <= sda;
                pair_slot_reg   <= pair_slot_next;
                first_data_reg  <= first_data_next;
                second_data_reg <= second_data_next;
                last_addr_reg   <= last_addr_next;
                lamp_reg        <= lamp_next;
            end
            // A register write loads the station address at once
            if (cfg_we)
            begin
                station_reg <= cfg_wdata;
            end
            else if (advance)
            begin
                station_reg <= station_next;
            end
        end
    end

    // Form the result from the updated state
    assign result.red_lamp   = lamp_next.red;
    assign result.green_lamp = lamp_next.green;
    assign result.relay_on   = lamp_next.relay;
    assign result.frame_done = done;
    assign result.frame_addr = last_addr_next;
    assign result.frame_data = pair_slot_next ? first_data_next : second_data_next;
    assign result.station_id = station_next;

    // A frame only closes on a rising clock line while receiving
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (receiving_reg && scl_rise))
        else $error("frame closed without a rising clock edge");

    // The bit counter rests at zero while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> (bit_count_reg == '0))
        else $error("bit counter not zero while idle");

    // Each closed frame flips the slot and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && done) |=>
            (!receiving_reg && pair_slot_reg != $past(pair_slot_reg)))
        else $error("frame close did not flip slot or drop receive");

endmodule
